// ===== src/pdf_pkg.sv =====
package pdf_pkg;

   localparam int NUM_REQUESTS_DEFAULT = 256;
   localparam int REQ_ID_W = 8;
   localparam int LOAD_W = 13;
   localparam int RUN_LOAD_W = 18;
   localparam int CAP_W = 16;
   localparam int DROPS_W = 9;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'hFFFF;
   localparam logic [DROPS_W-1:0] MIN_DROPS_RESET = 9'd0;

   typedef enum logic [0:0] {
      OP_NODE = 1'b0,
      OP_END  = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      REG_CAPACITY  = 1'b0,
      REG_MIN_DROPS = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      REASON_OK         = 3'd0,
      REASON_INVALID    = 3'd1,
      REASON_CAPACITY   = 3'd2,
      REASON_EARLY_DROP = 3'd3,
      REASON_FEW_DROPS  = 3'd4
   } reason_type;

   typedef struct packed {
      logic                       opcode;
      logic [REQ_ID_W-1:0]        request_id;
      logic                       request_valid;
      logic signed [LOAD_W-1:0]   load_delta;
   } item_type;

   typedef struct packed {
      logic                       node_go;
      logic                       clear;
      logic [REQ_ID_W-1:0]        request_id;
      logic                       request_valid;
      logic signed [LOAD_W-1:0]   load_delta;
   } route_cmd_type;

   typedef struct packed {
      logic                       failed;
      reason_type                 reason;
      logic [DROPS_W-1:0]         drop_count;
   } route_stat_type;

endpackage

// ===== src/pdf_req_if.sv =====
interface pdf_req_if
   import pdf_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic                     opcode;
   logic [REQ_ID_W-1:0]      request_id;
   logic                     request_valid;
   logic signed [LOAD_W-1:0] load_delta;

   modport source (output valid, output opcode, output request_id, output request_valid,
                   output load_delta, input ready);
   modport sink (input valid, input opcode, input request_id, input request_valid,
                 input load_delta, output ready);
endinterface

// ===== src/pdf_rsp_if.sv =====
interface pdf_rsp_if
   import pdf_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic                 feasible;
   logic [2:0]           fail_reason;
   logic [DROPS_W-1:0]   distinct_drops;

   modport source (output valid, output feasible, output fail_reason, output distinct_drops,
                   input ready);
   modport sink (input valid, input feasible, input fail_reason, input distinct_drops,
                 output ready);
endinterface

// ===== src/pdf_route.sv =====
module pdf_route
   import pdf_pkg::*;
#(
   parameter int NUM_REQUESTS = NUM_REQUESTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  route_cmd_type      cmd,
   input  logic [CAP_W-1:0]   capacity,
   output route_stat_type     stat
);

   localparam int ID_SPAN = 1 << REQ_ID_W;
   localparam int MAP_DEPTH = (NUM_REQUESTS < ID_SPAN) ? NUM_REQUESTS : ID_SPAN;
   localparam int IDX_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam logic [DROPS_W-1:0] DROPS_MAX = '1;

   logic signed [RUN_LOAD_W-1:0] load_ff, load_in;
   logic [MAP_DEPTH-1:0]         picked_ff, picked_in;
   logic [MAP_DEPTH-1:0]         dropped_ff, dropped_in;
   logic [DROPS_W-1:0]           drop_count_ff, drop_count_in;
   logic                         failed_ff, failed_in;
   reason_type                   reason_ff, reason_in;

   logic                         in_range;
   logic [IDX_W-1:0]             idx;
   logic signed [RUN_LOAD_W-1:0] next_load;
   logic                         over_cap;
   logic                         is_pickup;
   logic                         picked_bit;
   logic                         dropped_bit;

   assign in_range = (32'(cmd.request_id) < NUM_REQUESTS);
   assign idx = IDX_W'(cmd.request_id);
   assign next_load = load_ff + RUN_LOAD_W'(cmd.load_delta);
   assign over_cap = next_load[RUN_LOAD_W-1]
                  || (next_load > $signed({2'b00, capacity}));
   assign is_pickup = !cmd.load_delta[LOAD_W-1] && (cmd.load_delta != '0);
   assign picked_bit = in_range && picked_ff[idx];
   assign dropped_bit = in_range && dropped_ff[idx];

   always_comb begin
      load_in = load_ff;
      picked_in = picked_ff;
      dropped_in = dropped_ff;
      drop_count_in = drop_count_ff;
      failed_in = failed_ff;
      reason_in = reason_ff;
      if (cmd.clear) begin
         load_in = '0;
         picked_in = '0;
         dropped_in = '0;
         drop_count_in = '0;
         failed_in = 1'b0;
         reason_in = REASON_OK;
      end else if (cmd.node_go && !failed_ff) begin
         if (!cmd.request_valid || !in_range) begin
            failed_in = 1'b1;
            reason_in = REASON_INVALID;
         end else begin
            load_in = next_load;
            if (over_cap) begin
               failed_in = 1'b1;
               reason_in = REASON_CAPACITY;
            end else if (is_pickup) begin
               picked_in[idx] = 1'b1;
            end else if (!picked_bit) begin
               failed_in = 1'b1;
               reason_in = REASON_EARLY_DROP;
            end else if (!dropped_bit) begin
               dropped_in[idx] = 1'b1;
               if (drop_count_ff != DROPS_MAX) begin
                  drop_count_in = drop_count_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= '0;
         picked_ff <= '0;
         dropped_ff <= '0;
         drop_count_ff <= '0;
         failed_ff <= 1'b0;
         reason_ff <= REASON_OK;
      end else begin
         load_ff <= load_in;
         picked_ff <= picked_in;
         dropped_ff <= dropped_in;
         drop_count_ff <= drop_count_in;
         failed_ff <= failed_in;
         reason_ff <= reason_in;
      end
   end

   assign stat.failed = failed_ff;
   assign stat.reason = reason_ff;
   assign stat.drop_count = drop_count_ff;

   assert property (@(posedge clock) disable iff (reset)
      (failed_ff && !cmd.clear) |=> (failed_ff && $stable(reason_ff)))
      else $error("Latched failure changed before the route was cleared.");

   assert property (@(posedge clock) disable iff (reset)
      !cmd.clear |=> ((drop_count_ff == $past(drop_count_ff))
                   || (drop_count_ff == $past(drop_count_ff) + 9'd1)))
      else $error("Drop count moved by more than one on a node.");

   assert property (@(posedge clock) disable iff (reset)
      (failed_ff && !cmd.clear) |=> ($stable(picked_ff) && $stable(dropped_ff)))
      else $error("Request maps changed after the route failed.");

   assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (!failed_ff && drop_count_ff == '0 && picked_ff == '0))
      else $error("Route state was not cleared after the end of a route.");

endmodule

// ===== src/pickup_delivery_feasibility.sv =====
// Channel   Direction  Moves
// req       in         one route node, or the end of a route
// rsp       out        verdict, reason and distinct drop count, once per route end
// csr       in/out     capacity at 0x0, min_drops at 0x4
//
// A request enters an input register and is evaluated there against the route state,
// so one request is taken every cycle unless a waiting result stalls an end request;
// one node per cycle sustained. An end request loads the result register once the
// result register is free, and clears the route state and both request maps at that edge.
// Reset clears all route state and returns capacity to 65535 and min_drops to 0.
// A waiting result stalls the input only once the next end request reaches the input
// register; node requests ahead of it are still taken every cycle.
module pickup_delivery_feasibility
   import pdf_pkg::*;
#(
   parameter int NUM_REQUESTS = NUM_REQUESTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   pdf_req_if.sink               req,
   pdf_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [CAP_W-1:0]    capacity_ff, capacity_in;
   logic [DROPS_W-1:0]  min_drops_ff, min_drops_in;
   logic                csr_write;
   reg_index_type       csr_index;

   logic                s1_valid_ff, s1_valid_in;
   item_type            s1_item_ff, s1_item_in;
   logic                s1_adv;
   logic                s1_fire;
   logic                s1_end;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_feasible_ff, rsp_feasible_in;
   reason_type          rsp_reason_ff, rsp_reason_in;
   logic [DROPS_W-1:0]  rsp_drops_ff, rsp_drops_in;

   route_cmd_type       cmd;
   route_stat_type      stat;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_index = reg_index_type'(csr_paddr[2]);

   always_comb begin
      capacity_in = capacity_ff;
      min_drops_in = min_drops_ff;
      if (csr_write) begin
         case (csr_index)
            REG_CAPACITY: capacity_in = csr_pwdata[CAP_W-1:0];
            REG_MIN_DROPS: min_drops_in = csr_pwdata[DROPS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_CAPACITY: csr_prdata = CSR_DATA_W'(capacity_ff);
         REG_MIN_DROPS: csr_prdata = CSR_DATA_W'(min_drops_ff);
         default: csr_prdata = '0;
      endcase
   end

   assign s1_end = (s1_item_ff.opcode == OP_END);
   assign s1_adv = !s1_valid_ff || !s1_end || !rsp_valid_ff || rsp.ready;
   assign s1_fire = s1_valid_ff && s1_adv;
   assign req.ready = s1_adv;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in = s1_item_ff;
      if (s1_adv) begin
         s1_valid_in = req.valid;
         s1_item_in.opcode = req.opcode;
         s1_item_in.request_id = req.request_id;
         s1_item_in.request_valid = req.request_valid;
         s1_item_in.load_delta = req.load_delta;
      end
   end

   assign cmd.node_go = s1_fire && !s1_end;
   assign cmd.clear = s1_fire && s1_end;
   assign cmd.request_id = s1_item_ff.request_id;
   assign cmd.request_valid = s1_item_ff.request_valid;
   assign cmd.load_delta = s1_item_ff.load_delta;

   pdf_route #(
      .NUM_REQUESTS (NUM_REQUESTS)
   ) u_route (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .capacity (capacity_ff),
      .stat     (stat)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_feasible_in = rsp_feasible_ff;
      rsp_reason_in = rsp_reason_ff;
      rsp_drops_in = rsp_drops_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.clear) begin
         rsp_valid_in = 1'b1;
         rsp_drops_in = stat.drop_count;
         if (stat.failed) begin
            rsp_feasible_in = 1'b0;
            rsp_reason_in = stat.reason;
         end else if (stat.drop_count < min_drops_ff) begin
            rsp_feasible_in = 1'b0;
            rsp_reason_in = REASON_FEW_DROPS;
         end else begin
            rsp_feasible_in = 1'b1;
            rsp_reason_in = REASON_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         min_drops_ff <= MIN_DROPS_RESET;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff <= capacity_in;
         min_drops_ff <= min_drops_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      rsp_feasible_ff <= rsp_feasible_in;
      rsp_reason_ff <= rsp_reason_in;
      rsp_drops_ff <= rsp_drops_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.feasible = rsp_feasible_ff;
   assign rsp.fail_reason = rsp_reason_ff;
   assign rsp.distinct_drops = rsp_drops_ff;

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.clear))
      else $error("A result appeared without an end request.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_feasible_ff == (rsp_reason_ff == REASON_OK)))
      else $error("Verdict and reason code disagree.");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !cmd.clear) |=> !rsp_valid_ff)
      else $error("A node request produced a result.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready && s1_valid_ff && s1_end) |-> !req.ready)
      else $error("An end request advanced over a stalled result.");

endmodule

// ===== dv/pickup_delivery_feasibility_test.sv =====
module pickup_delivery_feasibility_test;
   import pdf_pkg::*;

   localparam int MAX_IDLE = 10;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1000;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic               feasible;
      reason_type         reason;
      logic [DROPS_W-1:0] drops;
   } verdict_type;

   class feasibility_board;
      int unsigned capacity;
      int unsigned min_drops;
      int          load;
      bit          picked[NUM_REQUESTS_DEFAULT];
      bit          dropped[NUM_REQUESTS_DEFAULT];
      int unsigned drop_count;
      bit          failed;
      reason_type  latched;
      verdict_type pending[$];
      int          errors;

      function new();
         capacity = 32'(CAPACITY_RESET);
         min_drops = 32'(MIN_DROPS_RESET);
         errors = 0;
         clear_route();
      endfunction

      function void clear_route();
         load = 0;
         foreach (picked[i]) begin
            picked[i] = 1'b0;
            dropped[i] = 1'b0;
         end
         drop_count = 0;
         failed = 1'b0;
         latched = REASON_OK;
      endfunction

      function void complain(string text);
         if (errors < REPORT_LIMIT)
            $display("%s", text);
         errors++;
      endfunction

      function void set_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_CAPACITY: begin
               capacity = 32'(value[CAP_W-1:0]);
            end
            REG_MIN_DROPS: begin
               min_drops = 32'(value[DROPS_W-1:0]);
            end
            default: ;
         endcase
      endfunction

      function void check_register(reg_index_type idx, logic [CSR_DATA_W-1:0] got);
         logic [CSR_DATA_W-1:0] want;
         want = (idx == REG_CAPACITY) ? capacity : min_drops;
         if (got !== want)
            complain($sformatf("register %s read back %0h, expected %0h", idx.name(), got, want));
      endfunction

      function void latch(reason_type why);
         failed = 1'b1;
         latched = why;
      endfunction

      function void note_request(item_type it);
         int          delta;
         int          next;
         verdict_type v;
         if (it.opcode == OP_END) begin
            v.drops = DROPS_W'(drop_count);
            if (failed) begin
               v.feasible = 1'b0;
               v.reason = latched;
            end else if (drop_count < min_drops) begin
               v.feasible = 1'b0;
               v.reason = REASON_FEW_DROPS;
            end else begin
               v.feasible = 1'b1;
               v.reason = REASON_OK;
            end
            pending.push_back(v);
            clear_route();
            return;
         end
         if (failed)
            return;
         if (!it.request_valid || it.request_id >= NUM_REQUESTS_DEFAULT) begin
            latch(REASON_INVALID);
            return;
         end
         delta = int'(it.load_delta);
         next = load + delta;
         load = next;
         if (next < 0 || next > int'(capacity)) begin
            latch(REASON_CAPACITY);
            return;
         end
         if (delta > 0) begin
            picked[it.request_id] = 1'b1;
         end else if (!picked[it.request_id]) begin
            latch(REASON_EARLY_DROP);
         end else if (!dropped[it.request_id]) begin
            dropped[it.request_id] = 1'b1;
            if (drop_count < 511)
               drop_count++;
         end
      endfunction

      function void check_verdict(logic feasible, logic [2:0] reason,
                                  logic [DROPS_W-1:0] drops);
         verdict_type want;
         if (pending.size() == 0) begin
            complain($sformatf("unexpected verdict: feasible %0b reason %0d drops %0d",
                               feasible, reason, drops));
            return;
         end
         want = pending.pop_front();
         if (feasible !== want.feasible || reason !== want.reason || drops !== want.drops)
            complain($sformatf({"verdict mismatch: expected feasible %0b reason %0d drops %0d,",
                                " got feasible %0b reason %0d drops %0d"},
                               want.feasible, want.reason, want.drops,
                               feasible, reason, drops));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bit                    quiet = 1'b0;
   int                    sent_items = 0;
   int                    idle_cycles = 0;
   feasibility_board      board;

   pdf_req_if req_ch ();
   pdf_rsp_if rsp_ch ();

   pickup_delivery_feasibility dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      item_type seen;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen.opcode = req_ch.opcode;
            seen.request_id = req_ch.request_id;
            seen.request_valid = req_ch.request_valid;
            seen.load_delta = req_ch.load_delta;
            board.note_request(seen);
         end
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_verdict(rsp_ch.feasible, rsp_ch.fail_reason, rsp_ch.distinct_drops);
      end
   end

   always @(posedge clock) begin
      if (reset || csr_psel || (req_ch.valid && req_ch.ready) ||
          (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == STALL_LIMIT) begin
         $display("pickup_delivery_feasibility_test: errors");
         $finish;
      end
   end

   initial begin
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   task automatic send_request(input item_type it);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= it.opcode;
      req_ch.request_id <= it.request_id;
      req_ch.request_valid <= it.request_valid;
      req_ch.load_delta <= it.load_delta;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_items++;
   endtask

   task automatic send_node(input int id, input bit vld, input int delta);
      item_type it;
      it.opcode = OP_NODE;
      it.request_id = REQ_ID_W'(id);
      it.request_valid = vld;
      it.load_delta = LOAD_W'(delta);
      send_request(it);
   endtask

   task automatic send_end();
      item_type it;
      it.opcode = OP_END;
      it.request_id = REQ_ID_W'($urandom);
      it.request_valid = 1'($urandom_range(0, 1));
      it.load_delta = LOAD_W'($urandom);
      send_request(it);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(4 * int'(idx));
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.set_register(idx, value);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.check_register(idx, csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_route(input int nodes, input int amt_max, input int noise_pct);
      int open_ids[$];
      int open_amts[$];
      int id;
      int k;
      int amt;
      int pick;
      for (int n = 0; n < nodes; n++) begin
         if ($urandom_range(1, 100) <= noise_pct) begin
            send_node($urandom_range(0, 255), 1'($urandom_range(0, 1)),
                      int'($urandom_range(0, 8191)) - 4096);
         end else if (open_ids.size() == 0 || $urandom_range(0, 1)) begin
            id = $urandom_range(0, 255);
            amt = $urandom_range(1, amt_max);
            send_node(id, 1'b1, amt);
            open_ids.push_back(id);
            open_amts.push_back(amt);
         end else begin
            k = $urandom_range(0, open_ids.size() - 1);
            pick = $urandom_range(0, 9);
            if (pick == 0)
               amt = 0;
            else if (pick == 1)
               amt = $urandom_range(0, amt_max);
            else
               amt = open_amts[k];
            send_node(open_ids[k], 1'b1, -amt);
            open_ids.delete(k);
            open_amts.delete(k);
         end
      end
      send_end();
   endtask

   task automatic run_full_route();
      int order[NUM_REQUESTS_DEFAULT];
      int amts[NUM_REQUESTS_DEFAULT];
      int j;
      int swap;
      for (int i = 0; i < NUM_REQUESTS_DEFAULT; i++) begin
         order[i] = i;
         amts[i] = $urandom_range(1, 255);
         send_node(i, 1'b1, amts[i]);
      end
      for (int i = NUM_REQUESTS_DEFAULT - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         swap = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      foreach (order[i])
         send_node(order[i], 1'b1, -amts[order[i]]);
      send_end();
   endtask

   initial begin
      int cap;
      int floor_drops;
      int amt_max;
      int target;
      board = new();
      req_ch.valid <= 1'b0;
      req_ch.opcode <= OP_NODE;
      req_ch.request_id <= '0;
      req_ch.request_valid <= 1'b0;
      req_ch.load_delta <= '0;
      rsp_ch.ready <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_end();
      send_node(255, 1'b1, 4095);
      send_node(255, 1'b1, 0);
      send_node(255, 1'b1, -4095);
      send_end();
      send_node(0, 1'b1, -4096);
      send_node(1, 1'b1, 5);
      send_end();
      send_node(7, 1'b1, 0);
      send_end();
      send_node(3, 1'b0, 100);
      send_node(3, 1'b1, 100);
      send_end();
      settle();
      csr_write(REG_CAPACITY, 0);
      csr_write(REG_MIN_DROPS, 256);
      send_end();
      send_node(1, 1'b1, 1);
      send_end();
      settle();
      csr_write(REG_CAPACITY, 100);
      csr_write(REG_MIN_DROPS, 1);
      send_node(9, 1'b1, 100);
      send_node(9, 1'b1, 1);
      send_end();
      send_node(4, 1'b1, 50);
      send_node(4, 1'b1, -50);
      send_end();

      target = sent_items + RANDOM_ITEMS;
      settle();
      csr_write(REG_CAPACITY, 65535);
      csr_write(REG_MIN_DROPS, 256);
      run_full_route();
      while (sent_items < target) begin
         settle();
         case ($urandom_range(0, 5))
            0: cap = 0;
            1: cap = 65535;
            2: cap = $urandom_range(1, 255);
            3: cap = $urandom_range(256, 8191);
            default: cap = $urandom_range(0, 65535);
         endcase
         case ($urandom_range(0, 5))
            0: floor_drops = 0;
            1: floor_drops = 256;
            2, 3: floor_drops = $urandom_range(0, 4);
            default: floor_drops = $urandom_range(0, 256);
         endcase
         csr_write(REG_CAPACITY, cap);
         csr_write(REG_MIN_DROPS, floor_drops);
         amt_max = cap / 3;
         if (amt_max < 1)
            amt_max = 1;
         if (amt_max > 4095)
            amt_max = 4095;
         quiet = ($urandom_range(0, 4) == 0);
         repeat ($urandom_range(1, 4))
            run_route($urandom_range(0, 16), amt_max, $urandom_range(0, 8));
      end

      settle();
      if (board.errors == 0)
         $display("pickup_delivery_feasibility_test: clean");
      else
         $display("pickup_delivery_feasibility_test: errors");
      $finish;
   end

endmodule
